@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion shorthands for the matrix multiply engine
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/mme_pkg.sv @@
// ----------------------------------------------------------------------------
// mme_pkg
// shared constants, codes and types of the matrix multiply engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mme_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;
  localparam int FRAC_BITS      = 8;

  localparam int OP_W      = 2;
  localparam int ADDR_W    = 6;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W     = 3;
  localparam int OUT_DEPTH = 8;

  // input operation codes
  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // one queued compute job, dimensions captured at accept time
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] inner;
    logic [DIM_W-1:0] cols;
  } mme_cmd_t;

  // zero reads as one, anything above the array size reads as the size
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > max_dim) begin
      r = max_dim;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/mme_ram.sv @@
// ----------------------------------------------------------------------------
// mme_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/mme_front.sv @@
// ----------------------------------------------------------------------------
// mme_front
// input side: takes items, writes operand stores, queues compute jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mme_front import mme_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             push,
  output logic                             full,
  input  logic [OP_W-1:0]                  in_op,
  input  logic [ADDR_W-1:0]                in_address,
  input  logic signed [ELEM_WIDTH-1:0]     in_value,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [DIM_W-1:0]                 cfg_data,
  // store write port
  output logic                             we_a,
  output logic                             we_b,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] waddr,
  output logic [ELEM_WIDTH-1:0]            wdata,
  // job queue toward the back end
  input  logic                             back_busy,
  input  logic                             cmd_take,
  output logic                             cmd_vld,
  output mme_cmd_t                         cmd
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [DIM_W-1:0]  MAX_DIM_V = DIM_W'(MAX_DIM);
  localparam logic [ADDR_W:0]   DEPTH_V   = (ADDR_W + 1)'(DEPTH);

  logic [DIM_W-1:0] rows_r, inner_r, cols_r;
  logic             cmd_vld_r;
  mme_cmd_t         cmd_r;
  logic             accept;
  logic             addr_ok;
  logic             is_compute;

  // writes must not slip under a job that still has reads to issue
  assign full       = cmd_vld_r || back_busy;
  assign accept     = push && !full;
  assign is_compute = (in_op == OP_COMPUTE);
  assign addr_ok    = ({1'b0, in_address} < DEPTH_V);

  assign we_a  = accept && (in_op == OP_WRITE_A) && addr_ok;
  assign we_b  = accept && (in_op == OP_WRITE_B) && addr_ok;
  assign waddr = in_address[AW-1:0];
  assign wdata = in_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= clamp_dim(DIM_RESET, MAX_DIM_V);
      inner_r <= clamp_dim(DIM_RESET, MAX_DIM_V);
      cols_r  <= clamp_dim(DIM_RESET, MAX_DIM_V);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROWS:  rows_r  <= clamp_dim(cfg_data, MAX_DIM_V);
        REG_INNER: inner_r <= clamp_dim(cfg_data, MAX_DIM_V);
        REG_COLS:  cols_r  <= clamp_dim(cfg_data, MAX_DIM_V);
        default: begin
        end
      endcase
    end
  end

  // one-entry job queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else if (accept && is_compute) begin
      cmd_vld_r <= 1'b1;
    end else if (cmd_take) begin
      cmd_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_compute) begin
      cmd_r.rows  <= rows_r;
      cmd_r.inner <= inner_r;
      cmd_r.cols  <= cols_r;
    end
  end

  assign cmd_vld = cmd_vld_r;
  assign cmd     = cmd_r;

endmodule

@@ hw/rtl/mme_back.sv @@
// ----------------------------------------------------------------------------
// mme_back
// job sequencer, multiply-accumulate pipeline and result queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mme_back import mme_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // job queue
  input  logic                               cmd_vld,
  input  mme_cmd_t                           cmd,
  output logic                               cmd_take,
  output logic                               busy,
  // store read ports
  output logic                               rd_en,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] a_raddr,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] b_raddr,
  input  logic [ELEM_WIDTH-1:0]              a_rdata,
  input  logic [ELEM_WIDTH-1:0]              b_rdata,
  // results
  input  logic                               pop,
  output logic                               empty,
  output logic signed [ELEM_WIDTH-1:0]       out_product,
  output logic [POS_W-1:0]                   out_row,
  output logic [POS_W-1:0]                   out_col,
  output logic                               out_saturated,
  output logic                               out_last
);

  localparam int AW     = $clog2(MAX_DIM * MAX_DIM);
  localparam int IW     = $clog2(MAX_DIM);
  localparam int PW     = 2 * ELEM_WIDTH;
  localparam int ACC_W  = PW + 4;
  localparam int QW     = ACC_W - FRAC_BITS;
  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int PTR_W  = $clog2(OUT_DEPTH);
  localparam logic [ACC_W-1:0]      RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [ELEM_WIDTH-1:0] Q_MAX    = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic [ELEM_WIDTH-1:0] Q_MIN    = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

  // sequencer
  logic            busy_r, busy_nxt;
  mme_cmd_t        dims_r, dims_nxt;
  logic [IW-1:0]   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [AW-1:0]   a_base_r, a_base_nxt, b_addr_r, b_addr_nxt;
  logic            start, go, credit_ok;
  logic            i_last, j_last, k_last;

  // pipeline tags
  logic            s1_vld_r, s1_first_r, s1_klast_r, s1_elast_r;
  logic [IW-1:0]   s1_row_r, s1_col_r;
  logic            s2_vld_r, s2_first_r, s2_klast_r, s2_elast_r;
  logic [IW-1:0]   s2_row_r, s2_col_r;
  logic signed [PW-1:0] prod_r;
  logic            done_r, s3_elast_r;
  logic [IW-1:0]   s3_row_r, s3_col_r;
  logic [ACC_W-1:0] acc_r, acc_nxt;

  // rounding and saturation
  logic [ACC_W-1:0]        rnd;
  logic [QW-1:0]           q;
  logic [QW-ELEM_WIDTH:0]  q_top;
  logic                    q_ovf;
  logic [ELEM_WIDTH-1:0]   q_sat;

  // result queue
  logic [ELEM_WIDTH-1:0] fq_prod_r [OUT_DEPTH];
  logic [IW-1:0]         fq_row_r  [OUT_DEPTH];
  logic [IW-1:0]         fq_col_r  [OUT_DEPTH];
  logic                  fq_sat_r  [OUT_DEPTH];
  logic                  fq_last_r [OUT_DEPTH];
  logic [PTR_W-1:0]      wp_r, rp_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      res_r, res_nxt;
  logic                  pop_ok;

  assign i_last = (DIM_W'(i_r) == dims_r.rows  - DIM_W'(1));
  assign j_last = (DIM_W'(j_r) == dims_r.cols  - DIM_W'(1));
  assign k_last = (DIM_W'(k_r) == dims_r.inner - DIM_W'(1));

  // a new element needs a reserved slot in the result queue
  assign credit_ok = (res_r < CNT_W'(OUT_DEPTH));
  assign go        = busy_r && ((k_r != '0) || credit_ok);
  assign start     = cmd_vld && !busy_r;
  assign cmd_take  = !busy_r;
  assign busy      = busy_r;

  assign rd_en   = go;
  assign a_raddr = a_base_r + AW'(k_r);
  assign b_raddr = b_addr_r;

  always_comb begin
    busy_nxt   = busy_r;
    dims_nxt   = dims_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    a_base_nxt = a_base_r;
    b_addr_nxt = b_addr_r;
    if (start) begin
      busy_nxt   = 1'b1;
      dims_nxt   = cmd;
      i_nxt      = '0;
      j_nxt      = '0;
      k_nxt      = '0;
      a_base_nxt = '0;
      b_addr_nxt = '0;
    end else if (go) begin
      if (k_last) begin
        k_nxt = '0;
        if (j_last) begin
          j_nxt      = '0;
          b_addr_nxt = '0;
          if (i_last) begin
            busy_nxt = 1'b0;
          end else begin
            i_nxt      = i_r + IW'(1);
            a_base_nxt = a_base_r + AW'(dims_r.inner);
          end
        end else begin
          j_nxt      = j_r + IW'(1);
          b_addr_nxt = AW'(j_r) + AW'(1);
        end
      end else begin
        k_nxt      = k_r + IW'(1);
        b_addr_nxt = b_addr_r + AW'(dims_r.cols);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dims_r   <= dims_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    a_base_r <= a_base_nxt;
    b_addr_r <= b_addr_nxt;
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      s1_vld_r <= go;
      s2_vld_r <= s1_vld_r;
      done_r   <= s2_vld_r && s2_klast_r;
    end
  end

  assign acc_nxt = (s2_first_r ? '0 : acc_r) + {{(ACC_W-PW){prod_r[PW-1]}}, prod_r};

  always_ff @(posedge clk) begin
    s1_first_r <= (k_r == '0);
    s1_klast_r <= k_last;
    s1_elast_r <= i_last && j_last;
    s1_row_r   <= i_r;
    s1_col_r   <= j_r;

    prod_r     <= $signed(a_rdata) * $signed(b_rdata);
    s2_first_r <= s1_first_r;
    s2_klast_r <= s1_klast_r;
    s2_elast_r <= s1_elast_r;
    s2_row_r   <= s1_row_r;
    s2_col_r   <= s1_col_r;

    if (s2_vld_r) begin
      acc_r      <= acc_nxt;
      s3_elast_r <= s2_elast_r;
      s3_row_r   <= s2_row_r;
      s3_col_r   <= s2_col_r;
    end
  end

  // round half up, then clip to the element range
  assign rnd   = acc_r + RND_HALF;
  assign q     = rnd[ACC_W-1:FRAC_BITS];
  assign q_top = q[QW-1:ELEM_WIDTH-1];
  assign q_ovf = !((&q_top) || !(|q_top));
  assign q_sat = q_ovf ? (q[QW-1] ? Q_MIN : Q_MAX) : q[ELEM_WIDTH-1:0];

  assign pop_ok = pop && !empty;
  assign empty  = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    res_nxt = res_r;
    if (done_r && !pop_ok) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!done_r && pop_ok) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if ((go && (k_r == '0)) && !pop_ok) begin
      res_nxt = res_r + CNT_W'(1);
    end else if (!(go && (k_r == '0)) && pop_ok) begin
      res_nxt = res_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      res_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      res_r <= res_nxt;
      if (done_r) begin
        wp_r <= wp_r + PTR_W'(1);
      end
      if (pop_ok) begin
        rp_r <= rp_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_r) begin
      fq_prod_r[wp_r] <= q_sat;
      fq_row_r[wp_r]  <= s3_row_r;
      fq_col_r[wp_r]  <= s3_col_r;
      fq_sat_r[wp_r]  <= q_ovf;
      fq_last_r[wp_r] <= s3_elast_r;
    end
  end

  assign out_product   = fq_prod_r[rp_r];
  assign out_row       = POS_W'(fq_row_r[rp_r]);
  assign out_col       = POS_W'(fq_col_r[rp_r]);
  assign out_saturated = fq_sat_r[rp_r];
  assign out_last      = fq_last_r[rp_r];

endmodule

@@ hw/rtl/matrix_multiply_engine.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// dense fixed point matrix multiply, C = A x B, row-major, Q8.8 elements
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     push / full            in_op, in_address, in_value
//  result    empty / pop            out_product, out_row, out_col,
//                                   out_saturated, out_last
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  input can transfer every cycle while full is low; a compute job holds
//  full high from its transfer until its last operand read is issued, one
//  multiply-accumulate a cycle through the shared multiplier unless the
//  sequencer stalls because every result slot is held or reserved; results
//  pass through the store read, product and accumulator registers into the
//  eight-entry queue; reset is synchronous; operand stores are not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_multiply_engine import mme_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         push,
  output logic                         full,
  input  logic [OP_W-1:0]              in_op,
  input  logic [ADDR_W-1:0]            in_address,
  input  logic signed [ELEM_WIDTH-1:0] in_value,
  // result channel
  output logic                         empty,
  input  logic                         pop,
  output logic signed [ELEM_WIDTH-1:0] out_product,
  output logic [POS_W-1:0]             out_row,
  output logic [POS_W-1:0]             out_col,
  output logic                         out_saturated,
  output logic                         out_last,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [DIM_W-1:0]             cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  // store write side, driven by the front end
  logic                  we_a, we_b;
  logic [AW-1:0]         waddr;
  logic [ELEM_WIDTH-1:0] wdata;

  // store read side, driven by the sequencer
  logic                  rd_en;
  logic [AW-1:0]         a_raddr, b_raddr;
  logic [ELEM_WIDTH-1:0] a_rdata, b_rdata;

  // job hand-off between front and back
  logic     cmd_vld, cmd_take, back_busy;
  mme_cmd_t cmd;

  // front end: element writes, register file, job queue
  mme_front #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_op      (in_op),
    .in_address (in_address),
    .in_value   (in_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .we_a       (we_a),
    .we_b       (we_b),
    .waddr      (waddr),
    .wdata      (wdata),
    .back_busy  (back_busy),
    .cmd_take   (cmd_take),
    .cmd_vld    (cmd_vld),
    .cmd        (cmd)
  );

  // operand store for A
  mme_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // operand store for B
  mme_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // back end: walks i, j, k and drains results through its queue
  mme_back #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_vld       (cmd_vld),
    .cmd           (cmd),
    .cmd_take      (cmd_take),
    .busy          (back_busy),
    .rd_en         (rd_en),
    .a_raddr       (a_raddr),
    .b_raddr       (b_raddr),
    .a_rdata       (a_rdata),
    .b_rdata       (b_rdata),
    .pop           (pop),
    .empty         (empty),
    .out_product   (out_product),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_saturated (out_saturated),
    .out_last      (out_last)
  );

endmodule

@@ hw/rtl/mme_checker.sv @@
// ----------------------------------------------------------------------------
// mme_checker
// port-level assertions for the matrix multiply engine, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mme_checker import mme_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  push,
  input logic                  full,
  input logic [OP_W-1:0]       in_op,
  input logic                  empty,
  input logic                  pop,
  input logic [ELEM_WIDTH-1:0] out_product,
  input logic                  out_saturated
);

  localparam logic [ELEM_WIDTH-1:0] SAT_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic [ELEM_WIDTH-1:0] SAT_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

  logic compute_xfer;
  logic at_extreme;

  assign compute_xfer = push && !full && (in_op == OP_COMPUTE);
  assign at_extreme   = (out_product == SAT_MAX) || (out_product == SAT_MIN);

  // a compute transfer locks the input side
  `ASSERT_CLK(a_compute_locks_input, compute_xfer |=> full, "input open after compute")

  // reset leaves the block empty and open
  `ASSERT_NORST(a_reset_idle, !rst_n |=> empty && !full, "not idle after reset")

  // a waiting result stays put until it is taken
  `ASSERT_CLK(a_result_held, !empty && !pop |=> !empty && $stable(out_product), "result changed")

  // a clipped result sits at one end of the range
  `ASSERT_CLK(a_sat_extreme, !empty && out_saturated |-> at_extreme, "clip value wrong")

endmodule

bind matrix_multiply_engine mme_checker #(
  .ELEM_WIDTH (ELEM_WIDTH)
) u_mme_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .push          (push),
  .full          (full),
  .in_op         (in_op),
  .empty         (empty),
  .pop           (pop),
  .out_product   (out_product),
  .out_saturated (out_saturated)
);
